/* rtl/core/gdk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdk_pkg
// Shared types, constants and helper functions of the two-axis tilt filter.
// ----------------------------------------------------------------------------
package gdk_pkg;

    // Number of filtered axes (pitch, roll).
    localparam int AXES   = 2;
    localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

    // Field widths.
    localparam int ANG_W  = 32;
    localparam int COV_W  = 48;
    localparam int T_W    = 24;
    localparam int NOISE_W = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [T_W-1:0]     STEP_PERIOD_RST   = 24'd83886;
    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 31'd1966;
    localparam logic [31:0]        CROSS_NOISE_RST   = 32'd0;
    localparam logic [NOISE_W-1:0] DRIFT_NOISE_RST   = 31'd6554;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 31'd3276800;

    // Iteration counts of the sequential arithmetic units.
    localparam int MUL_STEPS = 4;
    localparam int DIV_STEPS = 80;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_PERIOD   = 3'd0,
        REG_ANGLE_NOISE   = 3'd1,
        REG_CROSS_NOISE   = 3'd2,
        REG_DRIFT_NOISE   = 3'd3,
        REG_MEASURE_NOISE = 3'd4
    } reg_idx_t;

    // Per-axis micro-operations, run in this order.
    typedef enum logic [3:0] {
        OP_TD   = 4'd0,   // T * drift
        OP_TR   = 4'd1,   // T * rate, then predicted angle
        OP_P2T  = 4'd2,   // P10 * T
        OP_P3T  = 4'd3,   // P11 * T
        OP_AP1T = 4'd4,   // AP01 * T
        OP_DIV0 = 4'd5,   // K0 = P'00 / S
        OP_DIV1 = 4'd6,   // K1 = P'10 / S
        OP_K0E  = 4'd7,   // angle correction
        OP_K1E  = 4'd8,   // drift correction
        OP_K0P0 = 4'd9,
        OP_K0P1 = 4'd10,
        OP_K1P0 = 4'd11,
        OP_K1P1 = 4'd12
    } op_t;

    localparam op_t OP_FIRST = OP_TD;
    localparam op_t OP_LAST  = OP_K1P1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_ISSUE = 2'd1,
        ST_WAIT  = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              in_load;
        logic              start;
        logic              wb;
        logic              out_load;
        op_t               op;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic div_done;
    } status_t;

    // Next micro-operation in the per-axis sequence.
    function automatic op_t next_op(input op_t op);
        op_t n;
        case (op)
            OP_TD:   n = OP_TR;
            OP_TR:   n = OP_P2T;
            OP_P2T:  n = OP_P3T;
            OP_P3T:  n = OP_AP1T;
            OP_AP1T: n = OP_DIV0;
            OP_DIV0: n = OP_DIV1;
            OP_DIV1: n = OP_K0E;
            OP_K0E:  n = OP_K1E;
            OP_K1E:  n = OP_K0P0;
            OP_K0P0: n = OP_K0P1;
            OP_K0P1: n = OP_K1P0;
            OP_K1P0: n = OP_K1P1;
            default: n = OP_FIRST;
        endcase
        return n;
    endfunction

    // Saturate a 50-bit sum to 48 bits.
    function automatic logic signed [COV_W-1:0] sat48(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd140737488355327;
        lo = -50'sd140737488355328;
        if (v > hi)
            return hi[COV_W-1:0];
        else if (v < lo)
            return lo[COV_W-1:0];
        else
            return v[COV_W-1:0];
    endfunction

    // Saturate a 50-bit sum to 32 bits.
    function automatic logic signed [ANG_W-1:0] sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd2147483647;
        lo = -50'sd2147483648;
        if (v > hi)
            return hi[ANG_W-1:0];
        else if (v < lo)
            return lo[ANG_W-1:0];
        else
            return v[ANG_W-1:0];
    endfunction

    // Magnitude of a 48-bit signed value as an unsigned 48-bit value.
    function automatic logic [COV_W-1:0] mag48(input logic signed [COV_W-1:0] v);
        return v[COV_W-1] ? COV_W'(-v) : COV_W'(v);
    endfunction

endpackage

/* rtl/core/gdk_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdk_mul
// Sequential signed multiplier: round(a*b / 2^n), n = 24 or 32, halves away
// from zero, saturated to 48 bits. Four 24x24 partial products, one a cycle.
// ----------------------------------------------------------------------------
module gdk_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            shift32,
    input  logic signed [gdk_pkg::COV_W-1:0] a,
    input  logic signed [gdk_pkg::COV_W-1:0] b,
    output logic                            done,
    output logic signed [gdk_pkg::COV_W-1:0] result
);

    logic                           busy_reg;
    logic [2:0]                     cnt_reg;
    logic                           done_reg;
    logic [gdk_pkg::COV_W-1:0]      x_reg;
    logic [gdk_pkg::COV_W-1:0]      y_reg;
    logic                           neg_reg;
    logic                           n32_reg;
    logic [95:0]                    acc_reg;
    logic signed [gdk_pkg::COV_W-1:0] res_reg;

    logic [23:0] x_half;
    logic [23:0] y_half;
    logic [47:0] part;
    logic [95:0] part_sh;
    logic [96:0] rnd;
    logic [96:0] quo;
    logic [96:0] lim;
    logic [gdk_pkg::COV_W-1:0] mag;
    logic signed [gdk_pkg::COV_W-1:0] res_next;

    // Partial product of the selected halves, placed at its weight.
    always_comb
    begin
        x_half = cnt_reg[1] ? x_reg[47:24] : x_reg[23:0];
        y_half = cnt_reg[0] ? y_reg[47:24] : y_reg[23:0];
        part   = x_half * y_half;
        case (cnt_reg[1:0])
            2'd0:    part_sh = {48'd0, part};
            2'd3:    part_sh = {part, 48'd0};
            default: part_sh = {24'd0, part, 24'd0};
        endcase
    end

    // Round, shift and saturate the finished product.
    always_comb
    begin
        rnd = {1'b0, acc_reg} + (n32_reg ? (97'd1 << 31) : (97'd1 << 23));
        quo = n32_reg ? (rnd >> 32) : (rnd >> 24);
        lim = neg_reg ? (97'd1 << 47) : ((97'd1 << 47) - 97'd1);
        mag = (quo > lim) ? lim[gdk_pkg::COV_W-1:0] : quo[gdk_pkg::COV_W-1:0];
        res_next = neg_reg ? -$signed(mag) : $signed(mag);
    end

    // Sequencing of the unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'(gdk_pkg::MUL_STEPS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    // Operands and accumulator.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= gdk_pkg::mag48(a);
            y_reg   <= gdk_pkg::mag48(b);
            neg_reg <= a[gdk_pkg::COV_W-1] ^ b[gdk_pkg::COV_W-1];
            n32_reg <= shift32;
            acc_reg <= 96'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'(gdk_pkg::MUL_STEPS))
                res_reg <= res_next;
            else
                acc_reg <= acc_reg + part_sh;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/gdk_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdk_div
// Sequential gain divider: (num * 2^32) / den truncated toward zero, one
// quotient bit a cycle, saturated to 48 bits. A non-positive den gives zero.
// ----------------------------------------------------------------------------
module gdk_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [gdk_pkg::COV_W-1:0] num,
    input  logic signed [gdk_pkg::COV_W:0]   den,
    output logic                             done,
    output logic signed [gdk_pkg::COV_W-1:0] result
);

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [79:0] dvd_reg;
    logic [47:0] d_reg;
    logic [47:0] rem_reg;
    logic [48:0] q_reg;
    logic        over_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic signed [gdk_pkg::COV_W-1:0] res_reg;

    logic [48:0] rem_sh;
    logic        q_bit;
    logic        ov;
    logic [48:0] lim;
    logic [47:0] mag;
    logic signed [gdk_pkg::COV_W-1:0] res_next;

    // One restoring step.
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[79]};
        q_bit  = (rem_sh >= {1'b0, d_reg});
    end

    // Saturated, signed quotient.
    always_comb
    begin
        ov  = over_reg | q_reg[48];
        lim = neg_reg ? (49'd1 << 47) : ((49'd1 << 47) - 49'd1);
        mag = (ov || (q_reg > lim)) ? lim[47:0] : q_reg[47:0];
        if (zero_reg)
            res_next = '0;
        else
            res_next = neg_reg ? -$signed(mag) : $signed(mag);
    end

    // Sequencing of the unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 7'(gdk_pkg::DIV_STEPS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
        end
    end

    // Dividend, remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {gdk_pkg::mag48(num), 32'd0};
            d_reg    <= den[47:0];
            rem_reg  <= 48'd0;
            q_reg    <= 49'd0;
            over_reg <= 1'b0;
            neg_reg  <= num[gdk_pkg::COV_W-1];
            zero_reg <= den[gdk_pkg::COV_W] || (den == '0);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'(gdk_pkg::DIV_STEPS))
            begin
                res_reg <= res_next;
            end
            else
            begin
                dvd_reg  <= {dvd_reg[78:0], 1'b0};
                rem_reg  <= q_bit ? 48'(rem_sh - {1'b0, d_reg}) : rem_sh[47:0];
                over_reg <= over_reg | q_reg[48];
                q_reg    <= {q_reg[47:0], q_bit};
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/gdk_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdk_dp
// Datapath: configuration registers, filter state, temporaries, the shared
// multiplier and divider, and the output register.
// ----------------------------------------------------------------------------
module gdk_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gdk_pkg::cmd_t                         cmd,
    output gdk_pkg::status_t                      status,
    input  logic                                  cfg_we,
    input  logic [gdk_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gdk_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [gdk_pkg::ANG_W-1:0]      accel_in [gdk_pkg::AXES],
    input  logic signed [gdk_pkg::ANG_W-1:0]      rate_in  [gdk_pkg::AXES],
    output logic signed [gdk_pkg::ANG_W-1:0]      est_out  [gdk_pkg::AXES]
);

    localparam int CW = gdk_pkg::COV_W;
    localparam int AW = gdk_pkg::ANG_W;

    // Configuration.
    logic [gdk_pkg::T_W-1:0]     step_period_reg;
    logic [gdk_pkg::NOISE_W-1:0] angle_noise_reg;
    logic [31:0]                 cross_noise_reg;
    logic [gdk_pkg::NOISE_W-1:0] drift_noise_reg;
    logic [gdk_pkg::NOISE_W-1:0] measure_noise_reg;

    // Filter state and sample.
    logic signed [AW-1:0] angle_reg [gdk_pkg::AXES];
    logic signed [AW-1:0] drift_reg [gdk_pkg::AXES];
    logic signed [CW-1:0] p_reg     [gdk_pkg::AXES][4];
    logic signed [AW-1:0] accel_reg [gdk_pkg::AXES];
    logic signed [AW-1:0] rate_reg  [gdk_pkg::AXES];
    logic signed [AW-1:0] est_reg   [gdk_pkg::AXES];

    // Per-axis temporaries.
    logic signed [CW-1:0] td_reg;
    logic signed [AW-1:0] pred_reg;
    logic signed [CW-1:0] ap0_reg;
    logic signed [CW-1:0] ap1_reg;
    logic signed [CW-1:0] pp0_reg;
    logic signed [CW-1:0] pp1_reg;
    logic signed [CW-1:0] pp2_reg;
    logic signed [CW-1:0] pp3_reg;
    logic signed [CW-1:0] k0_reg;
    logic signed [CW-1:0] k1_reg;

    logic signed [CW-1:0] an_w;
    logic signed [CW-1:0] cn_w;
    logic signed [CW-1:0] dn_w;
    logic signed [CW:0]   s_w;
    logic signed [CW-1:0] t_w;
    logic signed [AW:0]   e_w;
    logic signed [CW-1:0] e_x;
    logic signed [CW-1:0] mul_a;
    logic signed [CW-1:0] mul_b;
    logic                 mul_n32;
    logic signed [CW-1:0] div_num;
    logic                 is_div;
    logic                 mul_done;
    logic                 div_done;
    logic signed [CW-1:0] mul_res;
    logic signed [CW-1:0] div_res;
    logic signed [AW-1:0] ang_a;
    logic signed [AW-1:0] drf_a;
    logic signed [AW-1:0] acc_a;
    logic signed [AW-1:0] rat_a;

    // Widened noise terms, step period and innovation.
    always_comb
    begin
        an_w  = $signed({1'b0, angle_noise_reg, 16'd0});
        cn_w  = $signed({cross_noise_reg, 16'd0});
        dn_w  = $signed({1'b0, drift_noise_reg, 16'd0});
        s_w   = (CW+1)'(pp0_reg) + $signed({2'b0, measure_noise_reg, 16'd0});
        t_w   = $signed({24'd0, step_period_reg});
        ang_a = angle_reg[cmd.axis];
        drf_a = drift_reg[cmd.axis];
        acc_a = accel_reg[cmd.axis];
        rat_a = rate_reg[cmd.axis];
        e_w   = (AW+1)'(acc_a) - (AW+1)'(pred_reg);
        e_x   = CW'(e_w);
    end

    // Operand selection for the shared units.
    always_comb
    begin
        is_div  = (cmd.op == gdk_pkg::OP_DIV0) || (cmd.op == gdk_pkg::OP_DIV1);
        mul_n32 = 1'b1;
        mul_a   = k0_reg;
        mul_b   = e_x;
        div_num = (cmd.op == gdk_pkg::OP_DIV1) ? pp2_reg : pp0_reg;
        case (cmd.op)
            gdk_pkg::OP_TD:
            begin
                mul_a = t_w; mul_b = CW'(drf_a); mul_n32 = 1'b0;
            end
            gdk_pkg::OP_TR:
            begin
                mul_a = t_w; mul_b = CW'(rat_a); mul_n32 = 1'b0;
            end
            gdk_pkg::OP_P2T:
            begin
                mul_a = p_reg[cmd.axis][2]; mul_b = t_w; mul_n32 = 1'b0;
            end
            gdk_pkg::OP_P3T:
            begin
                mul_a = p_reg[cmd.axis][3]; mul_b = t_w; mul_n32 = 1'b0;
            end
            gdk_pkg::OP_AP1T:
            begin
                mul_a = ap1_reg; mul_b = t_w; mul_n32 = 1'b0;
            end
            gdk_pkg::OP_K1E:
            begin
                mul_a = k1_reg; mul_b = e_x;
            end
            gdk_pkg::OP_K0P0:
            begin
                mul_a = k0_reg; mul_b = pp0_reg;
            end
            gdk_pkg::OP_K0P1:
            begin
                mul_a = k0_reg; mul_b = pp1_reg;
            end
            gdk_pkg::OP_K1P0:
            begin
                mul_a = k1_reg; mul_b = pp0_reg;
            end
            gdk_pkg::OP_K1P1:
            begin
                mul_a = k1_reg; mul_b = pp1_reg;
            end
            default:
            begin
                mul_a = k0_reg; mul_b = e_x;
            end
        endcase
    end

    gdk_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.start & ~is_div),
        .shift32 (mul_n32),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    gdk_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start & is_div),
        .num    (div_num),
        .den    (s_w),
        .done   (div_done),
        .result (div_res)
    );

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;

    // Configuration registers, filter state and corrections.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg   <= gdk_pkg::STEP_PERIOD_RST;
            angle_noise_reg   <= gdk_pkg::ANGLE_NOISE_RST;
            cross_noise_reg   <= gdk_pkg::CROSS_NOISE_RST;
            drift_noise_reg   <= gdk_pkg::DRIFT_NOISE_RST;
            measure_noise_reg <= gdk_pkg::MEASURE_NOISE_RST;
            for (int i = 0; i < gdk_pkg::AXES; i++)
            begin
                angle_reg[i] <= '0;
                drift_reg[i] <= '0;
                for (int j = 0; j < 4; j++)
                    p_reg[i][j] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (gdk_pkg::reg_idx_t'(cfg_index))
                    gdk_pkg::REG_STEP_PERIOD:   step_period_reg   <= cfg_data[23:0];
                    gdk_pkg::REG_ANGLE_NOISE:   angle_noise_reg   <= cfg_data[30:0];
                    gdk_pkg::REG_CROSS_NOISE:   cross_noise_reg   <= cfg_data;
                    gdk_pkg::REG_DRIFT_NOISE:   drift_noise_reg   <= cfg_data[30:0];
                    gdk_pkg::REG_MEASURE_NOISE: measure_noise_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (cmd.wb)
            begin
                case (cmd.op)
                    gdk_pkg::OP_K0E:
                        angle_reg[cmd.axis] <= gdk_pkg::sat32(50'(pred_reg) + 50'(mul_res));
                    gdk_pkg::OP_K1E:
                        drift_reg[cmd.axis] <= gdk_pkg::sat32(50'(drf_a) + 50'(mul_res));
                    gdk_pkg::OP_K0P0:
                        p_reg[cmd.axis][0] <= gdk_pkg::sat48(50'(pp0_reg) - 50'(mul_res));
                    gdk_pkg::OP_K0P1:
                        p_reg[cmd.axis][1] <= gdk_pkg::sat48(50'(pp1_reg) - 50'(mul_res));
                    gdk_pkg::OP_K1P0:
                        p_reg[cmd.axis][2] <= gdk_pkg::sat48(50'(pp2_reg) - 50'(mul_res));
                    gdk_pkg::OP_K1P1:
                        p_reg[cmd.axis][3] <= gdk_pkg::sat48(50'(pp3_reg) - 50'(mul_res));
                    default: ;
                endcase
            end
        end
    end

    // Sample capture, prediction temporaries, gains and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            for (int i = 0; i < gdk_pkg::AXES; i++)
            begin
                accel_reg[i] <= accel_in[i];
                rate_reg[i]  <= rate_in[i];
            end
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < gdk_pkg::AXES; i++)
                est_reg[i] <= angle_reg[i];
        end
        if (cmd.wb)
        begin
            case (cmd.op)
                gdk_pkg::OP_TD:
                    td_reg <= mul_res;
                gdk_pkg::OP_TR:
                    pred_reg <= gdk_pkg::sat32(50'(ang_a) - 50'(td_reg) + 50'(mul_res));
                gdk_pkg::OP_P2T:
                    ap0_reg <= gdk_pkg::sat48(50'(p_reg[cmd.axis][0]) - 50'(mul_res));
                gdk_pkg::OP_P3T:
                begin
                    ap1_reg <= gdk_pkg::sat48(50'(p_reg[cmd.axis][1]) - 50'(mul_res));
                    pp2_reg <= gdk_pkg::sat48(50'(p_reg[cmd.axis][2]) - 50'(mul_res)
                                              + 50'(cn_w));
                    pp3_reg <= gdk_pkg::sat48(50'(p_reg[cmd.axis][3]) + 50'(dn_w));
                end
                gdk_pkg::OP_AP1T:
                begin
                    pp0_reg <= gdk_pkg::sat48(50'(ap0_reg) - 50'(mul_res) + 50'(an_w));
                    pp1_reg <= gdk_pkg::sat48(50'(ap1_reg) + 50'(cn_w));
                end
                gdk_pkg::OP_DIV0:
                    k0_reg <= div_res;
                gdk_pkg::OP_DIV1:
                    k1_reg <= div_res;
                default: ;
            endcase
        end
    end

    assign est_out = est_reg;

endmodule

/* rtl/core/gdk_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdk_ctrl
// Controller: accepts an item, steps each axis through its micro-operations
// on the shared units, and hands the result to the output register.
// ----------------------------------------------------------------------------
module gdk_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output gdk_pkg::cmd_t    cmd,
    input  gdk_pkg::status_t status
);

    gdk_pkg::state_t state_reg;
    gdk_pkg::state_t state_next;
    gdk_pkg::op_t    op_reg;
    gdk_pkg::op_t    op_next;
    logic [gdk_pkg::AXIS_W-1:0] axis_reg;
    logic [gdk_pkg::AXIS_W-1:0] axis_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            unit_done;
    logic            out_free;

    assign unit_done = status.mul_done | status.div_done;
    assign out_free  = ~out_valid_reg | ~out_stall;

    // Next state, operation and axis.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        axis_next  = axis_reg;
        case (state_reg)
            gdk_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gdk_pkg::ST_ISSUE;
                    op_next    = gdk_pkg::OP_FIRST;
                    axis_next  = '0;
                end
            end
            gdk_pkg::ST_ISSUE:
                state_next = gdk_pkg::ST_WAIT;
            gdk_pkg::ST_WAIT:
            begin
                if (unit_done)
                begin
                    op_next = gdk_pkg::next_op(op_reg);
                    if (op_reg == gdk_pkg::OP_LAST)
                    begin
                        if (axis_reg == gdk_pkg::AXIS_W'(gdk_pkg::AXES - 1))
                        begin
                            state_next = gdk_pkg::ST_DONE;
                            axis_next  = '0;
                        end
                        else
                        begin
                            state_next = gdk_pkg::ST_ISSUE;
                            axis_next  = axis_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = gdk_pkg::ST_ISSUE;
                    end
                end
            end
            gdk_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = gdk_pkg::ST_IDLE;
            end
            default:
                state_next = gdk_pkg::ST_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb
    begin
        cmd.in_load    = 1'b0;
        cmd.start      = 1'b0;
        cmd.wb         = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.op         = op_reg;
        cmd.axis       = axis_reg;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg & out_stall;
        case (state_reg)
            gdk_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.in_load = in_valid;
            end
            gdk_pkg::ST_ISSUE:
                cmd.start = 1'b1;
            gdk_pkg::ST_WAIT:
                cmd.wb = unit_done;
            gdk_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdk_pkg::ST_IDLE;
            op_reg        <= gdk_pkg::OP_FIRST;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/gyro_drift_kalman_tilt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_drift_kalman_tilt
// Two-axis (pitch, roll) angle and gyro drift Kalman filter in fixed point.
// ----------------------------------------------------------------------------
// Usage:
// An input item (accelerometer angles and gyro rates of both axes) is taken
// when in_valid is high and in_stall is low. One result item (est_pitch,
// est_roll) follows for each input item, offered with out_valid and taken
// when out_stall is low.
// Each axis runs 11 multiplications on one shared multiplier (four 24x24
// partial products) and two gain divisions on one shared divider (one
// quotient bit a cycle). A new item is taken once the previous one has
// reached the output register.
// When the receiver stalls, the result stays in the output register; the
// block still accepts and computes the next item, then waits until the
// output register is free.
// Configuration must be written through cfg_valid/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this.
// cfg_ready is always high. Reset clears angle, drift and covariance of both
// axes and loads the default register values.
// ----------------------------------------------------------------------------
module gyro_drift_kalman_tilt (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [gdk_pkg::ANG_W-1:0]     accel_pitch,
    input  logic signed [gdk_pkg::ANG_W-1:0]     accel_roll,
    input  logic signed [gdk_pkg::ANG_W-1:0]     rate_pitch,
    input  logic signed [gdk_pkg::ANG_W-1:0]     rate_roll,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [gdk_pkg::ANG_W-1:0]     est_pitch,
    output logic signed [gdk_pkg::ANG_W-1:0]     est_roll,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gdk_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gdk_pkg::CFG_DATA_W-1:0]       cfg_data
);

    gdk_pkg::cmd_t    cmd;
    gdk_pkg::status_t status;

    logic signed [gdk_pkg::ANG_W-1:0] accel_in [gdk_pkg::AXES];
    logic signed [gdk_pkg::ANG_W-1:0] rate_in  [gdk_pkg::AXES];
    logic signed [gdk_pkg::ANG_W-1:0] est_out  [gdk_pkg::AXES];

    // Axis 0 is pitch, axis 1 is roll.
    assign accel_in[0] = accel_pitch;
    assign accel_in[1] = accel_roll;
    assign rate_in[0]  = rate_pitch;
    assign rate_in[1]  = rate_roll;
    assign est_pitch   = est_out[0];
    assign est_roll    = est_out[1];
    assign cfg_ready   = 1'b1;

    gdk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    gdk_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accel_in  (accel_in),
        .rate_in   (rate_in),
        .est_out   (est_out)
    );

    // Once an item is taken, the block is busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a previous item is still in work");

    // The two arithmetic units never finish in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(status.mul_done && status.div_done))
        else $error("multiplier and divider finished together");

    // The output register is loaded only while the input side is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> in_stall)
        else $error("output loaded while accepting input");

    // A unit start is a single-cycle pulse.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !cmd.start)
        else $error("unit start held for more than one cycle");

endmodule

/* tb/sv/gyro_drift_kalman_tilt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_drift_kalman_tilt_checker
// Watches the input, output and register channels of the tilt filter. It keeps
// its own fixed-point copy of both axis filters and of the registers, predicts
// the estimated angles of each accepted item and compares every result item
// with the oldest prediction. It reports the failure count and the number of
// predictions still waiting.
// ----------------------------------------------------------------------------
module gyro_drift_kalman_tilt_checker
    import gdk_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [ANG_W-1:0]      accel_pitch,
    input  logic signed [ANG_W-1:0]      accel_roll,
    input  logic signed [ANG_W-1:0]      rate_pitch,
    input  logic signed [ANG_W-1:0]      rate_roll,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [ANG_W-1:0]      est_pitch,
    input  logic signed [ANG_W-1:0]      est_roll,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output int                           errors,
    output int                           pending
);

    typedef struct {
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] roll;
    } tilt_t;

    // Noise terms, covariance and gains are in Q16.32; the step period is Q0.24.
    longint t_period;
    longint q_angle;
    longint q_cross;
    longint q_drift;
    longint r_meas;

    longint angle_est [AXES];
    longint drift_est [AXES];
    longint cov [AXES][4];

    tilt_t est_angles_q [$];

    function automatic logic [63:0] magn(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Clamp a magnitude to 48 bits with the given sign.
    function automatic longint clamp_mag(input logic neg, input logic [127:0] m);
        logic [127:0] lim;
        lim = (128'd1 << (COV_W - 1)) - (neg ? 128'd0 : 128'd1);
        if (m > lim)
            m = lim;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint clamp_bits(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Product scaled down by 2^n, rounded half away from zero.
    function automatic longint mul_round(input longint a, input longint b, input int n);
        logic [127:0] x;
        x = 128'(magn(a)) * 128'(magn(b));
        x = x + (128'd1 << (n - 1));
        return clamp_mag((a < 0) != (b < 0), x >> n);
    endfunction

    // Gain quotient num * 2^32 / den, truncated toward zero.
    function automatic longint gain_quot(input longint num, input longint den);
        logic [127:0] q;
        q = {magn(num), 32'd0} / 128'(den);
        return clamp_mag(num < 0, q);
    endfunction

    // One predict and correct step of one axis; returns the new angle.
    function automatic longint axis_update(input int a, input longint accel,
                                           input longint rate);
        longint pred, e, s, k0, k1, ap0, ap1, pp0, pp1, pp2, pp3;
        k0 = 0;
        k1 = 0;
        pred = clamp_bits(angle_est[a] - mul_round(t_period, drift_est[a], 24)
                          + mul_round(t_period, rate, 24), ANG_W);
        ap0 = clamp_bits(cov[a][0] - mul_round(cov[a][2], t_period, 24), COV_W);
        ap1 = clamp_bits(cov[a][1] - mul_round(cov[a][3], t_period, 24), COV_W);
        pp0 = clamp_bits(ap0 - mul_round(ap1, t_period, 24) + q_angle, COV_W);
        pp1 = clamp_bits(ap1 + q_cross, COV_W);
        pp2 = clamp_bits(cov[a][2] - mul_round(cov[a][3], t_period, 24) + q_cross,
                         COV_W);
        pp3 = clamp_bits(cov[a][3] + q_drift, COV_W);
        // A non-positive innovation variance leaves both gains at zero.
        s = pp0 + r_meas;
        if (s > 0)
        begin
            k0 = gain_quot(pp0, s);
            k1 = gain_quot(pp2, s);
        end
        e = accel - pred;
        angle_est[a] = clamp_bits(pred + mul_round(k0, e, 32), ANG_W);
        drift_est[a] = clamp_bits(drift_est[a] + mul_round(k1, e, 32), ANG_W);
        cov[a][0] = clamp_bits(pp0 - mul_round(k0, pp0, 32), COV_W);
        cov[a][1] = clamp_bits(pp1 - mul_round(k0, pp1, 32), COV_W);
        cov[a][2] = clamp_bits(pp2 - mul_round(k1, pp0, 32), COV_W);
        cov[a][3] = clamp_bits(pp3 - mul_round(k1, pp1, 32), COV_W);
        return angle_est[a];
    endfunction

    assign pending = est_angles_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        tilt_t want;
        longint ap, ar;
        if (!rst_n)
        begin
            t_period = longint'(STEP_PERIOD_RST);
            q_angle  = longint'(ANGLE_NOISE_RST) <<< 16;
            q_cross  = longint'(signed'(CROSS_NOISE_RST)) <<< 16;
            q_drift  = longint'(DRIFT_NOISE_RST) <<< 16;
            r_meas   = longint'(MEASURE_NOISE_RST) <<< 16;
            for (int a = 0; a < AXES; a++)
            begin
                angle_est[a] = 0;
                drift_est[a] = 0;
                for (int j = 0; j < 4; j++)
                    cov[a][j] = 0;
            end
            est_angles_q.delete();
            errors = 0;
        end
        else
        begin
            // Register writes; indexes past the last register are ignored.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STEP_PERIOD:   t_period = longint'(cfg_data[T_W-1:0]);
                    REG_ANGLE_NOISE:   q_angle = longint'(cfg_data[NOISE_W-1:0]) <<< 16;
                    REG_CROSS_NOISE:   q_cross = longint'(signed'(cfg_data)) <<< 16;
                    REG_DRIFT_NOISE:   q_drift = longint'(cfg_data[NOISE_W-1:0]) <<< 16;
                    REG_MEASURE_NOISE: r_meas = longint'(cfg_data[NOISE_W-1:0]) <<< 16;
                    default: ;
                endcase
            end

            // Compare a result item with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (est_angles_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result item %0h %0h with no item pending",
                                 est_pitch, est_roll);
                end
                else
                begin
                    want = est_angles_q.pop_front();
                    if (want.pitch !== est_pitch || want.roll !== est_roll)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: pitch exp %0d got %0d, roll exp %0d got %0d",
                                     want.pitch, est_pitch, want.roll, est_roll);
                    end
                end
            end

            // Predict the result of an accepted input item.
            if (in_valid && !in_stall)
            begin
                ap = axis_update(0, longint'(accel_pitch), longint'(rate_pitch));
                ar = axis_update(1, longint'(accel_roll), longint'(rate_roll));
                want.pitch = ap[ANG_W-1:0];
                want.roll  = ar[ANG_W-1:0];
                est_angles_q.push_back(want);
            end
        end
    end

endmodule

/* tb/sv/gyro_drift_kalman_tilt_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_drift_kalman_tilt_tb
// Drives the tilt filter through several register settings, extremes among
// them, with directed edge-case samples and random sensor samples, random
// gaps on the input side and random stalls on the output side. A checker
// beside the block predicts and compares each result item.
// ----------------------------------------------------------------------------
module gyro_drift_kalman_tilt_tb;
    import gdk_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PHASES = 6;
    localparam logic [CFG_IDX_W-1:0] IDX_PAST_LAST = 3'd5;
    localparam int ANGLE_SPAN = 90 * 65536;
    localparam int RATE_SPAN = 250 * 65536;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [ANG_W-1:0] accel_pitch;
    logic signed [ANG_W-1:0] accel_roll;
    logic signed [ANG_W-1:0] rate_pitch;
    logic signed [ANG_W-1:0] rate_roll;
    logic out_valid;
    logic out_stall;
    logic signed [ANG_W-1:0] est_pitch;
    logic signed [ANG_W-1:0] est_roll;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;
    int quiet_cycles;
    logic no_gaps;

    gyro_drift_kalman_tilt u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .accel_pitch (accel_pitch),
        .accel_roll  (accel_roll),
        .rate_pitch  (rate_pitch),
        .rate_roll   (rate_roll),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .est_pitch   (est_pitch),
        .est_roll    (est_roll),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    gyro_drift_kalman_tilt_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .accel_pitch (accel_pitch),
        .accel_roll  (accel_roll),
        .rate_pitch  (rate_pitch),
        .rate_roll   (rate_roll),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .est_pitch   (est_pitch),
        .est_roll    (est_roll),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending)
    );

    // Clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog on cycles in which no item moves on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: once a result item is offered, a random stall before taking it.
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            w = no_gaps ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            while (!out_valid)
                @(negedge clk);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] t, input logic [31:0] qa,
                             input logic [31:0] qc, input logic [31:0] qd,
                             input logic [31:0] r);
        write_reg(REG_STEP_PERIOD, t);
        write_reg(REG_ANGLE_NOISE, qa);
        write_reg(REG_CROSS_NOISE, qc);
        write_reg(REG_DRIFT_NOISE, qd);
        write_reg(REG_MEASURE_NOISE, r);
    endtask

    // Offer one sample after a random gap and wait until it is taken.
    task automatic send_sample(input logic [31:0] ap, input logic [31:0] ar,
                               input logic [31:0] rp, input logic [31:0] rr);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        accel_pitch <= ap;
        accel_roll  <= ar;
        rate_pitch  <= rp;
        rate_roll   <= rr;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic [31:0] near_value(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Mostly plausible tilt samples, some full-range noise.
    task automatic send_random;
        if ($urandom_range(0, 9) < 8)
            send_sample(near_value(ANGLE_SPAN), near_value(ANGLE_SPAN),
                        near_value(RATE_SPAN), near_value(RATE_SPAN));
        else
            send_sample($urandom, $urandom, $urandom, $urandom);
    endtask

    // Extremes of every field.
    task automatic send_extremes;
        send_sample(32'h0, 32'h0, 32'h0, 32'h0);
        send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_sample(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_sample(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        send_sample(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA);
        send_sample(32'hFFFFFFFF, 32'h00000001, 32'h00000001, 32'hFFFFFFFF);
        send_sample(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_sample(32'h0, 32'h0, 32'h0, 32'h0);
    endtask

    // Let every pending result drain before touching the registers.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        accel_pitch = '0;
        accel_roll  = '0;
        rate_pitch  = '0;
        rate_roll   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        no_gaps     = 1'b0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                // Reset defaults stand in the first phase.
                1: write_all(32'hFFFFFF, 32'd0, 32'd0, 32'd0, 32'd1);
                2: write_all(32'd1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                             32'h7FFFFFFF);
                // Large positive cross noise with tiny R drives S negative.
                3: write_all(32'hFFFFFF, 32'd0, 32'h7FFFFFFF, 32'd0, 32'd1);
                4:
                begin
                    write_all($urandom, $urandom, $urandom, $urandom,
                              $urandom_range(1, 32'h7FFFFFFF));
                    write_reg(IDX_PAST_LAST, $urandom);
                    write_reg(3'($urandom_range(IDX_PAST_LAST, 7)), $urandom);
                end
                default: write_all(32'd83886, 32'd1966, 32'd0, 32'd6554, 32'd3276800);
            endcase
            no_gaps = (ph == 2 || ph == 5);
            if (ph == 0 || ph == 1 || ph == 3)
                send_extremes();
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random();
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/gdk_pkg.sv
rtl/core/gdk_mul.sv
rtl/core/gdk_div.sv
rtl/core/gdk_dp.sv
rtl/core/gdk_ctrl.sv
rtl/core/gyro_drift_kalman_tilt.sv
tb/sv/gyro_drift_kalman_tilt_checker.sv
tb/sv/gyro_drift_kalman_tilt_tb.sv
